// ===== rtl/mtlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Memory trace line parser package
// Shared constants, the command record passed from the parser to the result
// sequencer, and the hex digit decoder.
// ----------------------------------------------------------------------------
package mtlp_pkg;

    localparam int ADDRESS_BITS_DEF = 61;
    localparam int QUEUE_DEPTH_DEF  = 4;
    localparam int HEX_W            = 64;
    localparam int CNT_W            = 64;

    localparam logic [CNT_W-1:0] MAX_RECORDS_RESET = '1;

    // trace text characters
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] HEX_TEN  = 8'd10;

    // access type codes; modify only lives inside the command record
    localparam logic [1:0] TYPE_READ   = 2'd0;
    localparam logic [1:0] TYPE_WRITE  = 2'd1;
    localparam logic [1:0] TYPE_FETCH  = 2'd2;
    localparam logic [1:0] TYPE_MODIFY = 2'd3;

    localparam logic KIND_RECORD  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // everything one input byte produces
    typedef struct packed {
        logic             has_rec;
        logic [1:0]       rec_type;
        logic [HEX_W-1:0] addr;
        logic             has_sum;
        logic [CNT_W-1:0] rec_cnt;
        logic [CNT_W-1:0] line_cnt;
        logic [CNT_W-1:0] skip_cnt;
    } t_cmd;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        logic       ok;
        v  = 8'd0;
        ok = 1'b0;
        priority if (c >= CH_0 && c <= CH_9) begin
            v  = c - CH_0;
            ok = 1'b1;
        end else if (c >= CH_LC_A && c <= CH_LC_F) begin
            v  = c - CH_LC_A + HEX_TEN;
            ok = 1'b1;
        end else if (c >= CH_UC_A && c <= CH_UC_F) begin
            v  = c - CH_UC_A + HEX_TEN;
            ok = 1'b1;
        end else begin
            v  = 8'd0;
            ok = 1'b0;
        end
        return {ok, v[3:0]};
    endfunction

endpackage

// ===== rtl/memory_trace_line_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Memory trace line parser
// Turns a text memory trace, one byte per transaction, into access records
// and an end-of-stream summary.
// ----------------------------------------------------------------------------
// Takes one trace byte per clock cycle while full is low; full rises only when
// all QUEUE_DEPTH entries of the command queue between parser and result
// sequencer hold commands. Each byte is classified in its accepting cycle and,
// if it ends a record or the stream, leaves one command in the queue; the
// sequencer then delivers one result per cycle while pop is high: one for a
// load, store or fetch, two for a modify, plus one summary at end of stream.
// Results appear at the earliest in the cycle after the byte that causes them.
// The max_records limit must be written on the configuration port only while
// idle (not enforced by the block) and is checked at each line start.
module memory_trace_line_parser #(
    parameter int ADDRESS_BITS = mtlp_pkg::ADDRESS_BITS_DEF,
    parameter int QUEUE_DEPTH  = mtlp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  i_char_byte,
    input  logic                        i_end_of_stream,
    input  logic                        i_cfg_we,
    input  logic [mtlp_pkg::CNT_W-1:0]  i_cfg_wdata,
    output logic                        empty,
    input  logic                        pop,
    output logic                        o_result_kind,
    output logic [1:0]                  o_access_type,
    output logic [ADDRESS_BITS-1:0]     o_address,
    output logic                        o_last,
    output logic [mtlp_pkg::CNT_W-1:0]  o_records_written,
    output logic [mtlp_pkg::CNT_W-1:0]  o_lines_read,
    output logic [mtlp_pkg::CNT_W-1:0]  o_lines_skipped
);

    logic           accept, cmd_push, q_pop;
    mtlp_pkg::t_cmd cmd_in, cmd_head;

    assign accept = push && !full;

    mtlp_line_front #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_char_byte     (i_char_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_cmd_push      (cmd_push),
        .o_cmd           (cmd_in)
    );

    mtlp_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (cmd_head),
        .o_empty (empty)
    );

    mtlp_result_back #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd_head),
        .i_q_empty         (empty),
        .o_q_pop           (q_pop),
        .pop               (pop),
        .o_result_kind     (o_result_kind),
        .o_access_type     (o_access_type),
        .o_address         (o_address),
        .o_last            (o_last),
        .o_records_written (o_records_written),
        .o_lines_read      (o_lines_read),
        .o_lines_skipped   (o_lines_skipped)
    );

endmodule

// ===== rtl/mtlp_cmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Small register queue between the line parser and the result sequencer.
// ----------------------------------------------------------------------------
module mtlp_cmd_queue #(
    parameter int DEPTH = mtlp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mtlp_pkg::t_cmd  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output mtlp_pkg::t_cmd  o_data,
    output logic            o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    mtlp_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic do_push, do_pop;

    assign o_full  = (r_count == DEPTH_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("command queue count beyond depth");

endmodule

// ===== rtl/mtlp_line_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line parser front end
// Classifies each byte of the trace, gathers the hex address, keeps the
// counters and the record limit, and issues one command per byte that yields
// results.
// ----------------------------------------------------------------------------
module mtlp_line_front #(
    parameter int ADDRESS_BITS = mtlp_pkg::ADDRESS_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [7:0]                  i_char_byte,
    input  logic                        i_end_of_stream,
    input  logic                        i_cfg_we,
    input  logic [mtlp_pkg::CNT_W-1:0]  i_cfg_wdata,
    output logic                        o_cmd_push,
    output mtlp_pkg::t_cmd              o_cmd
);

    typedef enum logic [2:0] {
        PH_LINE_START,
        PH_AFTER_SPACE,
        PH_AFTER_DIGIT,
        PH_SCAN,
        PH_DISCARD,
        PH_STOPPED
    } t_phase;

    t_phase                        r_phase, n_phase;
    logic [1:0]                    r_pend_type, n_pend_type;
    logic [mtlp_pkg::HEX_W-1:0]    r_hex, n_hex;
    logic                          r_digit, n_digit;
    logic [mtlp_pkg::CNT_W-1:0]    r_rec_cnt, n_rec_cnt;
    logic [mtlp_pkg::CNT_W-1:0]    r_line_cnt, n_line_cnt;
    logic [mtlp_pkg::CNT_W-1:0]    r_skip_cnt, n_skip_cnt;
    logic [mtlp_pkg::CNT_W-1:0]    r_max_records;

    logic [4:0] hexd;
    logic       is_blank, is_nl, fin_bad, do_finish;
    logic [mtlp_pkg::CNT_W-1:0] fin_inc;

    assign hexd     = mtlp_pkg::hex_digit(i_char_byte);
    assign is_blank = (i_char_byte == mtlp_pkg::CH_SPACE) || (i_char_byte == mtlp_pkg::CH_TAB);
    assign is_nl    = (i_char_byte == mtlp_pkg::CH_NL);
    // any bit at or above the address width rejects the line
    assign fin_bad  = !r_digit || (|r_hex[mtlp_pkg::HEX_W-1:ADDRESS_BITS]);
    assign fin_inc  = (r_pend_type == mtlp_pkg::TYPE_MODIFY) ? 64'd2 : 64'd1;

    always_comb begin
        n_phase     = r_phase;
        n_pend_type = r_pend_type;
        n_hex       = r_hex;
        n_digit     = r_digit;
        n_rec_cnt   = r_rec_cnt;
        n_line_cnt  = r_line_cnt;
        n_skip_cnt  = r_skip_cnt;
        do_finish   = 1'b0;
        o_cmd       = '0;
        o_cmd_push  = 1'b0;

        if (i_end_of_stream) begin
            unique case (r_phase)
                PH_AFTER_SPACE, PH_AFTER_DIGIT: n_skip_cnt = r_skip_cnt + 1'b1;
                PH_SCAN:                        do_finish  = 1'b1;
                default: ;
            endcase
            if (r_phase != PH_STOPPED) begin
                n_phase = PH_LINE_START;
            end
        end else begin
            unique case (r_phase)
                PH_LINE_START: begin
                    if (r_rec_cnt >= r_max_records) begin
                        n_phase = PH_STOPPED;
                    end else begin
                        n_line_cnt = r_line_cnt + 1'b1;
                        priority if (i_char_byte == mtlp_pkg::CH_I) begin
                            n_pend_type = mtlp_pkg::TYPE_FETCH;
                            n_hex       = '0;
                            n_digit     = 1'b0;
                            n_phase     = PH_SCAN;
                        end else if (i_char_byte == mtlp_pkg::CH_SPACE) begin
                            n_phase = PH_AFTER_SPACE;
                        end else if (i_char_byte >= mtlp_pkg::CH_0
                                     && i_char_byte <= mtlp_pkg::CH_2) begin
                            n_pend_type = i_char_byte[1:0];
                            n_phase     = PH_AFTER_DIGIT;
                        end else begin
                            n_skip_cnt = r_skip_cnt + 1'b1;
                            n_phase    = is_nl ? PH_LINE_START : PH_DISCARD;
                        end
                    end
                end
                PH_AFTER_SPACE: begin
                    priority if (i_char_byte == mtlp_pkg::CH_L) begin
                        n_pend_type = mtlp_pkg::TYPE_READ;
                        n_phase     = PH_SCAN;
                    end else if (i_char_byte == mtlp_pkg::CH_S) begin
                        n_pend_type = mtlp_pkg::TYPE_WRITE;
                        n_phase     = PH_SCAN;
                    end else if (i_char_byte == mtlp_pkg::CH_M) begin
                        n_pend_type = mtlp_pkg::TYPE_MODIFY;
                        n_phase     = PH_SCAN;
                    end else begin
                        n_skip_cnt = r_skip_cnt + 1'b1;
                        n_phase    = is_nl ? PH_LINE_START : PH_DISCARD;
                    end
                    n_hex   = '0;
                    n_digit = 1'b0;
                end
                PH_AFTER_DIGIT: begin
                    if (i_char_byte == mtlp_pkg::CH_SPACE) begin
                        n_phase = PH_SCAN;
                        n_hex   = '0;
                        n_digit = 1'b0;
                    end else begin
                        n_skip_cnt = r_skip_cnt + 1'b1;
                        n_phase    = is_nl ? PH_LINE_START : PH_DISCARD;
                    end
                end
                PH_SCAN: begin
                    priority if (!r_digit && is_blank) begin
                        // leading blanks
                    end else if (hexd[4]) begin
                        n_hex   = {r_hex[mtlp_pkg::HEX_W-5:0], hexd[3:0]};
                        n_digit = 1'b1;
                    end else begin
                        do_finish = 1'b1;
                        n_phase   = is_nl ? PH_LINE_START : PH_DISCARD;
                    end
                end
                PH_DISCARD: begin
                    if (is_nl) begin
                        n_phase = PH_LINE_START;
                    end
                end
                PH_STOPPED: ;
                default: n_phase = PH_LINE_START;
            endcase
        end

        if (do_finish) begin
            if (fin_bad) begin
                n_skip_cnt = r_skip_cnt + 1'b1;
            end else begin
                n_rec_cnt      = r_rec_cnt + fin_inc;
                o_cmd.has_rec  = 1'b1;
                o_cmd.rec_type = r_pend_type;
                o_cmd.addr     = r_hex;
            end
            n_hex   = '0;
            n_digit = 1'b0;
        end

        if (i_end_of_stream) begin
            o_cmd.has_sum  = 1'b1;
            o_cmd.rec_cnt  = n_rec_cnt;
            o_cmd.line_cnt = n_line_cnt;
            o_cmd.skip_cnt = n_skip_cnt;
        end

        o_cmd_push = i_accept && (o_cmd.has_rec || o_cmd.has_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_LINE_START;
            r_pend_type   <= mtlp_pkg::TYPE_READ;
            r_hex         <= '0;
            r_digit       <= 1'b0;
            r_rec_cnt     <= '0;
            r_line_cnt    <= '0;
            r_skip_cnt    <= '0;
            r_max_records <= mtlp_pkg::MAX_RECORDS_RESET;
        end else begin
            if (i_cfg_we) begin
                r_max_records <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_phase     <= n_phase;
                r_pend_type <= n_pend_type;
                r_hex       <= n_hex;
                r_digit     <= n_digit;
                r_rec_cnt   <= n_rec_cnt;
                r_line_cnt  <= n_line_cnt;
                r_skip_cnt  <= n_skip_cnt;
            end
        end
    end

    a_stopped_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_STOPPED |=> r_phase == PH_STOPPED)
        else $error("parser left the stopped phase without reset");

    a_eos_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_end_of_stream |-> o_cmd_push && o_cmd.has_sum)
        else $error("end of stream transaction without summary command");

endmodule

// ===== rtl/mtlp_result_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result sequencer back end
// Expands the command at the queue head into its results: up to two trace
// records and an optional end summary, one per cycle while pop is high.
// ----------------------------------------------------------------------------
module mtlp_result_back #(
    parameter int ADDRESS_BITS = mtlp_pkg::ADDRESS_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mtlp_pkg::t_cmd              i_cmd,
    input  logic                        i_q_empty,
    output logic                        o_q_pop,
    input  logic                        pop,
    output logic                        o_result_kind,
    output logic [1:0]                  o_access_type,
    output logic [ADDRESS_BITS-1:0]     o_address,
    output logic                        o_last,
    output logic [mtlp_pkg::CNT_W-1:0]  o_records_written,
    output logic [mtlp_pkg::CNT_W-1:0]  o_lines_read,
    output logic [mtlp_pkg::CNT_W-1:0]  o_lines_skipped
);

    logic [1:0] r_sub;
    logic [1:0] rec_num, total;
    logic       is_rec, is_modify, take;

    assign is_modify = (i_cmd.rec_type == mtlp_pkg::TYPE_MODIFY);
    assign rec_num   = !i_cmd.has_rec ? 2'd0 : (is_modify ? 2'd2 : 2'd1);
    assign total     = rec_num + {1'b0, i_cmd.has_sum};
    assign is_rec    = (r_sub < rec_num);
    assign o_last    = (r_sub == total - 2'd1);
    assign take      = pop && !i_q_empty;
    assign o_q_pop   = take && o_last;

    always_comb begin
        o_result_kind     = is_rec ? mtlp_pkg::KIND_RECORD : mtlp_pkg::KIND_SUMMARY;
        o_access_type     = mtlp_pkg::TYPE_READ;
        o_address         = '0;
        o_records_written = '0;
        o_lines_read      = '0;
        o_lines_skipped   = '0;
        if (is_rec) begin
            // a modify goes out as a load then a store
            o_access_type = is_modify ? {1'b0, r_sub[0]} : i_cmd.rec_type;
            o_address     = i_cmd.addr[ADDRESS_BITS-1:0];
        end else begin
            o_records_written = i_cmd.rec_cnt;
            o_lines_read      = i_cmd.line_cnt;
            o_lines_skipped   = i_cmd.skip_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 2'd0;
        end else if (take) begin
            r_sub <= o_last ? 2'd0 : r_sub + 2'd1;
        end
    end

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_empty && o_result_kind == mtlp_pkg::KIND_SUMMARY |-> o_last)
        else $error("summary result not last of its transaction");

    a_no_modify_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_empty |-> o_access_type != mtlp_pkg::TYPE_MODIFY)
        else $error("modify code reached the result port");

    a_sub_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_sub == 2'd0)
        else $error("result index not cleared after command retired");

endmodule

// ===== bench/memory_trace_line_parser_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Memory trace line parser testbench
// Feeds trace text byte by byte through the push side, predicts every access
// record and end-of-stream summary in a line parser of its own, and checks
// each popped result in order. Covers tag forms, malformed lines, address
// range limits, cut-short lines, back-pressure and the record limit.
// ----------------------------------------------------------------------------
module memory_trace_line_parser_test;
    import mtlp_pkg::*;

    localparam int          ADDR_W      = ADDRESS_BITS_DEF;
    localparam int unsigned CYCLE_LIMIT = 600000;

    typedef enum logic [2:0] {
        LP_START,
        LP_SPACE_TAG,
        LP_DIGIT_TAG,
        LP_HEX,
        LP_SKIP_REST,
        LP_HALTED
    } line_phase_t;

    typedef struct {
        logic             kind;
        logic [1:0]       acc_type;
        logic [ADDR_W-1:0] addr;
        logic             last;
        logic [CNT_W-1:0] recs;
        logic [CNT_W-1:0] lines;
        logic [CNT_W-1:0] skips;
    } trace_result_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [7:0]        i_char_byte = 8'd0;
    logic              i_end_of_stream = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CNT_W-1:0]  i_cfg_wdata = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic              o_result_kind;
    logic [1:0]        o_access_type;
    logic [ADDR_W-1:0] o_address;
    logic              o_last;
    logic [CNT_W-1:0]  o_records_written;
    logic [CNT_W-1:0]  o_lines_read;
    logic [CNT_W-1:0]  o_lines_skipped;

    // parser state of the predictor
    line_phase_t      phase = LP_START;
    logic [1:0]       pend_type = TYPE_READ;
    logic [HEX_W-1:0] hex_acc = '0;
    logic             got_digit = 1'b0;
    logic [CNT_W-1:0] rec_cnt = '0;
    logic [CNT_W-1:0] line_cnt = '0;
    logic [CNT_W-1:0] skip_cnt = '0;
    logic [CNT_W-1:0] rec_limit = MAX_RECORDS_RESET;

    trace_result_t pending_records[$];
    int            errors = 0;
    int unsigned   parsed_bytes = 0;
    int unsigned   cycles = 0;
    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;
    int unsigned   hold_req = 0;
    int unsigned   hold_left = 0;

    memory_trace_line_parser u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_char_byte       (i_char_byte),
        .i_end_of_stream   (i_end_of_stream),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .empty             (empty),
        .pop               (pop),
        .o_result_kind     (o_result_kind),
        .o_access_type     (o_access_type),
        .o_address         (o_address),
        .o_last            (o_last),
        .o_records_written (o_records_written),
        .o_lines_read      (o_lines_read),
        .o_lines_skipped   (o_lines_skipped)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic int unsigned nibble_of(logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return 32'(c - CH_0);
        if (c >= CH_LC_A && c <= CH_LC_F)
            return 32'(c - CH_LC_A + HEX_TEN);
        if (c >= CH_UC_A && c <= CH_UC_F)
            return 32'(c - CH_UC_A + HEX_TEN);
        return 16;
    endfunction

    function automatic void add_record(logic [1:0] t, logic [HEX_W-1:0] a);
        trace_result_t r;
        r.kind     = KIND_RECORD;
        r.acc_type = t;
        r.addr     = a[ADDR_W-1:0];
        r.last     = 1'b0;
        r.recs     = '0;
        r.lines    = '0;
        r.skips    = '0;
        pending_records.push_back(r);
        rec_cnt++;
    endfunction

    function automatic void close_address();
        if (!got_digit || hex_acc[HEX_W-1:ADDR_W] != '0) begin
            skip_cnt++;
        end else if (pend_type == TYPE_MODIFY) begin
            add_record(TYPE_READ, hex_acc);
            add_record(TYPE_WRITE, hex_acc);
        end else begin
            add_record(pend_type, hex_acc);
        end
        hex_acc   = '0;
        got_digit = 1'b0;
    endfunction

    function automatic void drop_line(logic [7:0] c);
        skip_cnt++;
        phase = (c == CH_NL) ? LP_START : LP_SKIP_REST;
    endfunction

    function automatic void open_address(logic [1:0] t);
        pend_type = t;
        hex_acc   = '0;
        got_digit = 1'b0;
        phase     = LP_HEX;
    endfunction

    function automatic void parse_trace_byte(logic [7:0] c, logic eos);
        int unsigned   n0;
        int unsigned   d;
        trace_result_t r;
        n0 = pending_records.size();
        if (eos) begin
            if (phase == LP_SPACE_TAG || phase == LP_DIGIT_TAG)
                skip_cnt++;
            else if (phase == LP_HEX)
                close_address();
            if (phase != LP_HALTED)
                phase = LP_START;
            r.kind     = KIND_SUMMARY;
            r.acc_type = TYPE_READ;
            r.addr     = '0;
            r.last     = 1'b0;
            r.recs     = rec_cnt;
            r.lines    = line_cnt;
            r.skips    = skip_cnt;
            pending_records.push_back(r);
        end else begin
            if (phase != LP_SKIP_REST && phase != LP_HALTED)
                parsed_bytes++;
            case (phase)
                LP_START: begin
                    if (rec_cnt >= rec_limit) begin
                        phase = LP_HALTED;
                    end else begin
                        line_cnt++;
                        if (c == CH_I)
                            open_address(TYPE_FETCH);
                        else if (c == CH_SPACE)
                            phase = LP_SPACE_TAG;
                        else if (c >= CH_0 && c <= CH_2) begin
                            pend_type = 2'(c - CH_0);
                            phase     = LP_DIGIT_TAG;
                        end else
                            drop_line(c);
                    end
                end
                LP_SPACE_TAG: begin
                    if (c == CH_L)
                        open_address(TYPE_READ);
                    else if (c == CH_S)
                        open_address(TYPE_WRITE);
                    else if (c == CH_M)
                        open_address(TYPE_MODIFY);
                    else
                        drop_line(c);
                end
                LP_DIGIT_TAG: begin
                    if (c == CH_SPACE)
                        open_address(pend_type);
                    else
                        drop_line(c);
                end
                LP_HEX: begin
                    d = nibble_of(c);
                    if (!got_digit && (c == CH_SPACE || c == CH_TAB)) begin
                        // leading blanks before the address
                    end else if (d < 16) begin
                        hex_acc   = {hex_acc[HEX_W-5:0], d[3:0]};
                        got_digit = 1'b1;
                    end else begin
                        close_address();
                        phase = (c == CH_NL) ? LP_START : LP_SKIP_REST;
                    end
                end
                LP_SKIP_REST: begin
                    if (c == CH_NL)
                        phase = LP_START;
                end
                default: ;
            endcase
        end
        if (pending_records.size() > n0) begin
            r = pending_records.pop_back();
            r.last = 1'b1;
            pending_records.push_back(r);
        end
    endfunction

    // ---------------- checking ----------------

    function automatic void show_result(string tag, trace_result_t r);
        $display("  %s kind=%0d type=%0d addr=%h last=%0d recs=%0d lines=%0d skips=%0d",
                 tag, r.kind, r.acc_type, r.addr, r.last, r.recs, r.lines, r.skips);
    endfunction

    function automatic void check_result();
        trace_result_t got;
        trace_result_t want;
        got.kind     = o_result_kind;
        got.acc_type = o_access_type;
        got.addr     = o_address;
        got.last     = o_last;
        got.recs     = o_records_written;
        got.lines    = o_lines_read;
        got.skips    = o_lines_skipped;
        if (pending_records.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("result with nothing expected at cycle %0d", cycles);
                show_result("actual  ", got);
            end
        end else begin
            want = pending_records.pop_front();
            if (got.kind !== want.kind || got.acc_type !== want.acc_type ||
                got.addr !== want.addr || got.last !== want.last ||
                got.recs !== want.recs || got.lines !== want.lines ||
                got.skips !== want.skips) begin
                errors++;
                if (errors <= 10) begin
                    $display("result mismatch at cycle %0d", cycles);
                    show_result("expected", want);
                    show_result("actual  ", got);
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full)
                parse_trace_byte(i_char_byte, i_end_of_stream);
            if (i_cfg_we)
                rec_limit = i_cfg_wdata;
            if (pop && !empty)
                check_result();
        end
    end

    // receiver side: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (!i_rst_n) begin
            pop = 1'b0;
        end else if (hold_left != 0) begin
            pop = 1'b0;
            hold_left--;
        end else begin
            pop = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ---------------- stimulus ----------------

    task automatic send_item(logic [7:0] c, logic eos);
        // each cycle idles with the set percentage
        push = 1'b0;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
            @(negedge i_clk);
        push            = 1'b1;
        i_char_byte     = c;
        i_end_of_stream = eos;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        push = 1'b0;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic send_eos();
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic wait_idle();
        int unsigned guard;
        guard = 0;
        push  = 1'b0;
        while (pending_records.size() != 0 && guard < 100000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_limit(logic [CNT_W-1:0] v);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    function automatic logic [7:0] rand_hex_char();
        int unsigned v;
        v = $urandom_range(15);
        if (v < 10)
            return 8'(CH_0 + v);
        return 8'(($urandom_range(1) ? CH_UC_A : CH_LC_A) + v - 10);
    endfunction

    task automatic send_random_line();
        logic [7:0]  line_q[$];
        int unsigned r;
        int unsigned n;
        r = $urandom_range(99);
        if (r < 15) begin
            line_q.push_back(CH_I);
        end else if (r < 60) begin
            line_q.push_back(CH_SPACE);
            line_q.push_back(r < 30 ? CH_L : (r < 45 ? CH_S : CH_M));
        end else if (r < 75) begin
            line_q.push_back(8'(CH_0 + $urandom_range(2)));
            line_q.push_back(CH_SPACE);
        end else if (r < 83) begin
            // broken tag
            case ($urandom_range(2))
                0: line_q.push_back(8'($urandom_range(255)));
                1: begin
                    line_q.push_back(CH_SPACE);
                    line_q.push_back(8'($urandom_range(255)));
                end
                default: begin
                    line_q.push_back(8'(CH_0 + $urandom_range(2)));
                    line_q.push_back(8'($urandom_range(255)));
                end
            endcase
        end else if (r < 90) begin
            repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(255)));
        end
        repeat ($urandom_range(0, 3)) line_q.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
        r = $urandom_range(99);
        n = (r < 5) ? 0 : (r < 15) ? $urandom_range(13, 17) : $urandom_range(1, 8);
        repeat (n) line_q.push_back(rand_hex_char());
        r = $urandom_range(99);
        if (r >= 90) begin
            line_q.push_back(8'($urandom_range(255)));
        end else if (r >= 70) begin
            line_q.push_back(8'h2C);
            line_q.push_back(8'(CH_0 + $urandom_range(1, 9)));
        end
        line_q.push_back(CH_NL);
        foreach (line_q[i]) begin
            if ($urandom_range(99) < 2)
                send_eos();
            send_item(line_q[i], 1'b0);
        end
        if ($urandom_range(99) < 5)
            send_eos();
    endtask

    // ---------------- tests ----------------

    task automatic test_access_types();
        send_text("I0\n");
        send_text(" LFf\n");
        send_text(" S\taB\n");
        send_text(" M 7e\n");
        send_text("0 1\n");
        send_text("1 c\n");
        send_text("2 \t D9,4\n");
        wait_idle();
    endtask

    task automatic test_malformed_lines();
        send_text("X1\n");
        send_text(" Q1\n");
        send_text("3 1\n");
        send_text("1X\n");
        send_text(" L zz\n");
        send_text(" M\t\n");
        send_text("\n");
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(CH_NL, 1'b0);
        wait_idle();
    endtask

    task automatic test_address_extremes();
        send_text("I1FFFFFFFFFFFFFFF\n");
        send_text(" S2000000000000000\n");
        // seventeen digits shift the leading one out of the accumulator
        send_text("I10000000000000000\n");
        send_text("I 12 trailing text\n");
        wait_idle();
    endtask

    task automatic test_end_of_stream();
        send_eos();
        send_text(" ");
        send_eos();
        send_text("1");
        send_eos();
        send_text("I");
        send_eos();
        send_text(" M 42");
        send_eos();
        send_text("I5\n");
        send_eos();
        wait_idle();
    endtask

    task automatic test_random_traffic(int tx_pct, int rx_pct, int unsigned n_bytes);
        int unsigned start;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start       = parsed_bytes;
        while (parsed_bytes - start < n_bytes)
            send_random_line();
        wait_idle();
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 250;
        repeat (25) begin
            send_item(CH_I, 1'b0);
            repeat ($urandom_range(1, 3)) send_item(rand_hex_char(), 1'b0);
            send_item(CH_NL, 1'b0);
        end
        wait_idle();
    endtask

    task automatic test_record_limit();
        set_limit(rec_cnt + 1);
        // the modify crosses the limit but still gives both transactions
        send_text(" M 9\n");
        send_text("I1\n");
        send_eos();
        wait_idle();
        // raising the limit does not restart a halted parser
        set_limit(MAX_RECORDS_RESET);
        send_text("I2\n");
        send_eos();
        wait_idle();
        set_limit('0);
        send_eos();
        wait_idle();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        set_limit(MAX_RECORDS_RESET);
        test_access_types();
        test_malformed_lines();
        test_address_extremes();
        test_end_of_stream();
        test_random_traffic(31, 76, 60);
        set_limit(rec_cnt + 100000);
        test_random_traffic(76, 31, 60);
        set_limit(MAX_RECORDS_RESET);
        test_random_traffic(0, 0, 60);
        test_backpressure();
        test_record_limit();

        repeat (16) @(posedge i_clk);
        if (pending_records.size() != 0)
            errors++;
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mtlp_pkg.sv
rtl/mtlp_cmd_queue.sv
rtl/mtlp_line_front.sv
rtl/mtlp_result_back.sv
rtl/memory_trace_line_parser.sv
bench/memory_trace_line_parser_test.sv
